// File: hw/rtl/srms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srms_pkg: shared types and constants of the stereo block RMS meter
// Field widths, register indexes and the control words between the meter's
// lanes, the merge stage and the top level.
// ----------------------------------------------------------------------------
package srms_pkg;

    localparam int DEF_MAX_BLOCK_FRAMES = 1024;

    localparam int NUM_LANES  = 2;
    localparam int SAMPLE_W   = 16;
    localparam int SQ_W       = 31;   // square of a 16-bit magnitude, up to 2^30
    localparam int QUO_W      = 31;   // mean square never exceeds 2^30
    localparam int RMS_W      = 16;
    localparam int ROOT_W     = 32;
    localparam int SQRT_STEPS = 16;

    localparam int THRESH_W   = 24;
    localparam int RPT_CNT_W  = 25;
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 24'd5000;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_ENABLE    = 8'd1;

    // Control from the top level to each lane.
    typedef struct packed {
        logic frame_valid;  // a frame is accepted this cycle
        logic block_end;    // that frame closes the block
    } srms_lane_ctl_t;

    // Status from each lane to the merge stage.
    typedef struct packed {
        logic             done;
        logic [RMS_W-1:0] rms;
    } srms_lane_res_t;

endpackage

// File: hw/rtl/stereo_block_rms_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_block_rms_meter: block RMS level meter for stereo Q1.15 audio
// Two channel lanes square and sum samples; at each block end they divide
// and take a square root, and a merge stage emits one word per block.
// ----------------------------------------------------------------------------
// Each input word is one stereo frame. Frames are squared and summed per
// channel until a frame with s_tlast set, or the frame that brings the block
// to MAX_BLOCK_FRAMES, closes the block. That frame produces one output word
// holding floor(sqrt(floor(sum / frames))) for each channel, and tuser flags
// a level report when the count of frames since the last report has reached
// report_threshold and report_enable is set; a flagged report restarts that
// count, which otherwise saturates at 2^25-1. A frame that does not close a
// block does not make the meter busy. A closing frame runs each lane's
// restoring divider, one quotient bit per cycle over the
// 31 + log2(MAX_BLOCK_FRAMES) bit sum, and then its square root unit, one
// result bit per cycle; the next frame is accepted once the merge stage
// has taken both results. A finished result waits in the output register
// without holding up new frames unless a second block closes before it is
// taken.
// Configuration writes are accepted every cycle and are meant to be issued
// only while the meter is idle.
// ----------------------------------------------------------------------------
module stereo_block_rms_meter
    import srms_pkg::*;
#(
    parameter int MAX_BLOCK_FRAMES = DEF_MAX_BLOCK_FRAMES
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Input frames.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [15:0] left_sample, [31:16] right_sample
    input  logic                  s_tlast,   // last_frame

    // Block results.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [15:0] left level, [31:16] right level
    output logic                  m_tuser,   // report_event

    // Register writes: index 0 report_threshold, index 1 report_enable.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_BLOCK_FRAMES + 1);

    logic [THRESH_W-1:0]  threshold_reg;
    logic                 enable_reg;
    logic [CNT_W-1:0]     block_cnt_reg, block_cnt_next;
    logic [RPT_CNT_W-1:0] report_cnt_reg, report_cnt_inc;
    logic                 report_reg;
    logic                 busy_reg;

    logic                 in_accept;
    logic                 block_end;
    logic                 report_now;
    logic                 take;
    srms_lane_ctl_t       lane_ctl;
    srms_lane_res_t       lane_res [NUM_LANES];

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy_reg;
    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        block_cnt_next = block_cnt_reg + 1'b1;
        block_end      = s_tlast || (block_cnt_next == CNT_W'(MAX_BLOCK_FRAMES));
        report_cnt_inc = (report_cnt_reg == '1) ? report_cnt_reg : report_cnt_reg + 1'b1;
        report_now     = (report_cnt_inc >= RPT_CNT_W'(threshold_reg)) && enable_reg;
        lane_ctl.frame_valid = in_accept;
        lane_ctl.block_end   = in_accept && block_end;
    end

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            enable_reg    <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_REPORT_THRESHOLD) begin
                threshold_reg <= cfg_data[THRESH_W-1:0];
            end else if (cfg_index == REG_REPORT_ENABLE) begin
                enable_reg <= cfg_data[0];
            end
        end
    end

    // Frame counters and the block-in-flight flag. The report decision is
    // taken when the closing frame is accepted and travels with the block.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_cnt_reg  <= '0;
            report_cnt_reg <= '0;
            busy_reg       <= 1'b0;
        end else begin
            if (in_accept) begin
                if (block_end) begin
                    block_cnt_reg  <= '0;
                    report_cnt_reg <= report_now ? '0 : report_cnt_inc;
                    busy_reg       <= 1'b1;
                end else begin
                    block_cnt_reg  <= block_cnt_next;
                    report_cnt_reg <= report_cnt_inc;
                end
            end else if (take) begin
                busy_reg <= 1'b0;
            end
        end
        if (in_accept && block_end) begin
            report_reg <= report_now;
        end
    end

    // One lane per channel; lane 0 is left, lane 1 is right.
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        srms_lane #(
            .MAX_BLOCK_FRAMES(MAX_BLOCK_FRAMES)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (lane_ctl),
            .sample  (s_tdata[g*SAMPLE_W +: SAMPLE_W]),
            .frames  (block_cnt_next),
            .take    (take),
            .res     (lane_res[g])
        );
    end

    srms_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .lane_res (lane_res),
        .report   (report_reg),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: hw/rtl/srms_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srms_lane: one channel of the RMS meter
// Accumulates squared samples, then divides the sum by the frame count one
// quotient bit per cycle and takes the integer square root one bit per cycle.
// ----------------------------------------------------------------------------
module srms_lane
    import srms_pkg::*;
#(
    parameter int MAX_BLOCK_FRAMES = DEF_MAX_BLOCK_FRAMES,
    localparam int CNT_W = $clog2(MAX_BLOCK_FRAMES + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  srms_lane_ctl_t      ctl,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [CNT_W-1:0]    frames,
    input  logic                take,
    output srms_lane_res_t      res
);

    localparam int SUM_W  = SQ_W + $clog2(MAX_BLOCK_FRAMES);
    localparam int STEP_W = $clog2(SUM_W + 1);

    localparam logic [1:0] ST_ACC  = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SUM_W-1:0]  dq_reg, dq_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [QUO_W-1:0]  x_reg, x_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [ROOT_W-1:0] bit_reg, bit_next;

    logic [SAMPLE_W-1:0]   mag;
    logic [2*SAMPLE_W-1:0] prod;
    logic [SUM_W-1:0]      sum_add;
    logic [CNT_W:0]        rem_sh;
    logic [CNT_W:0]        rem_sub;
    logic                  rem_ge;
    logic [SUM_W-1:0]      dq_step;
    logic [ROOT_W-1:0]     trial;
    logic                  x_ge;
    logic [ROOT_W-1:0]     x_sub;

    always_comb begin
        mag     = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
        prod    = mag * mag;
        sum_add = sum_reg + SUM_W'(prod[SQ_W-1:0]);

        rem_sh  = {rem_reg, dq_reg[SUM_W-1]};
        rem_ge  = rem_sh >= {1'b0, div_reg};
        rem_sub = rem_sh - {1'b0, div_reg};
        dq_step = {dq_reg[SUM_W-2:0], rem_ge};

        trial   = root_reg + bit_reg;
        x_ge    = ROOT_W'(x_reg) >= trial;
        x_sub   = ROOT_W'(x_reg) - trial;
    end

    always_comb begin
        state_next = state_reg;
        sum_next   = sum_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        unique case (state_reg)
            ST_ACC: begin
                if (ctl.frame_valid) begin
                    if (ctl.block_end) begin
                        sum_next   = '0;
                        dq_next    = sum_add;
                        rem_next   = '0;
                        div_next   = frames;
                        step_next  = STEP_W'(SUM_W - 1);
                        state_next = ST_DIV;
                    end else begin
                        sum_next = sum_add;
                    end
                end
            end
            ST_DIV: begin
                dq_next   = dq_step;
                rem_next  = rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    x_next     = dq_step[QUO_W-1:0];
                    root_next  = '0;
                    bit_next   = ROOT_W'(1) << (2 * (SQRT_STEPS - 1));
                    step_next  = STEP_W'(SQRT_STEPS - 1);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (x_ge) begin
                    x_next    = x_sub[QUO_W-1:0];
                    root_next = (root_reg >> 1) + bit_reg;
                end else begin
                    root_next = root_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (take) begin
                    state_next = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
            sum_reg   <= '0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
        end
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        step_reg <= step_next;
        x_reg    <= x_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign res.done = (state_reg == ST_DONE);
    assign res.rms  = root_reg[RMS_W-1:0];

endmodule

// File: hw/rtl/srms_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srms_merge: result merge stage of the RMS meter
// Waits for every lane, then packs the channel levels and the report flag
// into the output register.
// ----------------------------------------------------------------------------
module srms_merge
    import srms_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  srms_lane_res_t             lane_res [NUM_LANES],
    input  logic                       report,
    output logic                       take,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [NUM_LANES*RMS_W-1:0] m_tdata,
    output logic                       m_tuser
);

    logic                       valid_reg;
    logic [NUM_LANES*RMS_W-1:0] data_reg, data_next;
    logic                       user_reg;
    logic                       all_done;

    always_comb begin
        all_done  = 1'b1;
        data_next = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            all_done = all_done & lane_res[i].done;
            data_next[i*RMS_W +: RMS_W] = lane_res[i].rms;
        end
    end

    assign take = all_done && (!valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
        if (take) begin
            data_reg <= data_next;
            user_reg <= report;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the stereo block RMS meter
// Drives stereo frames through the input stream, predicts the per-block RMS
// words and report flags in step, and compares every result word as it
// leaves the meter. Both stream sides idle at random, and the register port
// is exercised between phases while the meter is quiet.
// ----------------------------------------------------------------------------
module tb
    import srms_pkg::*;
();

    // The meter is built with its default block length so the overlong
    // block case is reachable in a reasonable number of frames.
    localparam int BLOCK_LIMIT   = DEF_MAX_BLOCK_FRAMES;
    // This many quiet cycles after the last result covers any trailing work
    // that a closing frame leaves in the meter.
    localparam int QUIET_CYCLES  = 80;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_FRAMES = 210;
    localparam int RANDOM_PHASES = 6;
    localparam int IDLE_PERCENT  = 8;

    localparam logic [THRESH_W-1:0]  THRESHOLD_MAX  = 24'hFFFFFF;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 8'hFF;

    // One expected result word: both channel levels and the report flag.
    typedef struct packed {
        logic [RMS_W-1:0] left_level;
        logic [RMS_W-1:0] right_level;
        logic             report;
    } level_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;   // [15:0] left_sample, [31:16] right_sample
    logic                  s_tlast   = 1'b0; // last_frame
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;          // [15:0] left level, [31:16] right level
    logic                  m_tuser;          // report_event
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predicted meter state, kept in step with every accepted frame word.
    logic [46:0]           left_energy;
    logic [46:0]           right_energy;
    logic [16:0]           block_frames;
    logic [RPT_CNT_W-1:0]  frames_since_report;
    logic [THRESH_W-1:0]   threshold_now;
    logic                  enable_now;

    level_t levels_due[$];
    int     fail_count  = 0;
    int     cycle_count = 0;
    // While set, neither stream side inserts idle cycles.
    bit     no_idle     = 1'b0;

    stereo_block_rms_meter #(
        .MAX_BLOCK_FRAMES(BLOCK_LIMIT)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // The square of a Q1.15 sample, taken on its magnitude so that -32768
    // gives 2^30 exactly.
    function automatic longint unsigned square_of(input logic signed [SAMPLE_W-1:0] smp);
        longint v;
        v = smp;
        if (v < 0) v = -v;
        return v * v;
    endfunction

    // Floor of the square root, built greedily from the top result bit down.
    function automatic logic [RMS_W-1:0] root_floor(input longint unsigned x);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = RMS_W; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= x) r = c;
        end
        return r[RMS_W-1:0];
    endfunction

    // Applies one accepted frame to the predicted state. Returns 1 and the
    // expected word when the frame closes a block, either by its last flag
    // or by filling the block to its maximum length.
    function automatic bit meter_take_frame(input logic signed [SAMPLE_W-1:0] l_smp,
                                            input logic signed [SAMPLE_W-1:0] r_smp,
                                            input logic last,
                                            output level_t lvl);
        left_energy  = left_energy + 47'(square_of(l_smp));
        right_energy = right_energy + 47'(square_of(r_smp));
        block_frames = block_frames + 17'd1;
        // The report count sticks at its top value instead of wrapping.
        if (frames_since_report != '1) frames_since_report = frames_since_report + 1'b1;
        lvl = '0;
        if (!last && block_frames < BLOCK_LIMIT) return 1'b0;
        lvl.left_level  = root_floor(64'(left_energy) / 64'(block_frames));
        lvl.right_level = root_floor(64'(right_energy) / 64'(block_frames));
        // A zero threshold is always met, so every block end is flagged
        // while reporting is on. With reporting off the count keeps running.
        lvl.report = (frames_since_report >= RPT_CNT_W'(threshold_now)) && enable_now;
        if (lvl.report) frames_since_report = '0;
        left_energy  = '0;
        right_energy = '0;
        block_frames = '0;
        return 1'b1;
    endfunction

    // Samples lean toward the extremes and small values near zero.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] v;
        v = SAMPLE_W'($urandom());
        case ($urandom_range(9))
            0: v = 16'sh8000;
            1: v = 16'sh7FFF;
            2: v = '0;
            3: v = SAMPLE_W'($urandom_range(255)) - 16'd128;
            default: ;
        endcase
        return v;
    endfunction

    // Sends one frame word. Called and returning at a falling edge; valid is
    // left high so that back-to-back words need no second assignment.
    task automatic send_frame(input logic signed [SAMPLE_W-1:0] l_smp,
                              input logic signed [SAMPLE_W-1:0] r_smp,
                              input logic last);
        level_t lvl;
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r_smp, l_smp};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        if (meter_take_frame(l_smp, r_smp, last, lvl)) levels_due.push_back(lvl);
        @(negedge aclk);
    endtask

    // A block of random frames with the last flag on its final frame.
    task automatic send_block(input int len);
        for (int i = 0; i < len; i++) begin
            send_frame(pick_sample(), pick_sample(), i == len - 1);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_REPORT_THRESHOLD) threshold_now = val[THRESH_W-1:0];
        else if (idx == REG_REPORT_ENABLE) enable_now = val[0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Stops the input stream and waits until every predicted word has come
    // out, then lets the meter settle before registers are touched.
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (levels_due.size() != 0) @(negedge aclk);
        repeat (QUIET_CYCLES) @(negedge aclk);
    endtask

    // Full-scale values of both signs, alternating bit patterns and short
    // multi-frame blocks, all under the reset register settings.
    task automatic test_directed();
        send_frame(16'sh8000, 16'sh8000, 1'b1);
        send_frame(16'sh7FFF, 16'sh8000, 1'b1);
        send_frame(16'sh0000, 16'sh0000, 1'b1);
        send_frame(16'sh5555, 16'shAAAA, 1'b1);
        send_frame(16'shAAAA, 16'sh5555, 1'b1);
        send_frame(16'sh7FFF, 16'sh0001, 1'b0);
        send_frame(16'sh8000, 16'shFFFF, 1'b1);
        send_frame(16'sh0001, 16'shFFFF, 1'b0);
        send_frame(16'shFFFF, 16'sh0001, 1'b0);
        send_frame(16'sh0002, 16'sh0003, 1'b1);
        send_frame(16'sh8000, 16'sh7FFF, 1'b0);
        send_frame(16'sh8000, 16'sh7FFF, 1'b0);
        send_frame(16'sh8000, 16'sh7FFF, 1'b1);
    endtask

    // A block that never sets the last flag must close at the maximum
    // length. It is all negative full scale, which gives the largest sums
    // and a level of exactly 32768; a short block follows right behind it.
    task automatic test_overlong_block();
        for (int i = 0; i < BLOCK_LIMIT; i++) begin
            send_frame(16'sh8000, 16'sh8000, 1'b0);
        end
        send_block(3);
    endtask

    // Small thresholds, including zero, so that the report
    // flag and the count restart can be followed block by block.
    task automatic test_report_flags();
        wait_quiet();
        write_reg(REG_REPORT_THRESHOLD, 24'd1);
        write_reg(REG_REPORT_ENABLE, 24'd1);
        repeat (3) send_block(1);
        send_block(4);
        wait_quiet();
        write_reg(REG_REPORT_THRESHOLD, 24'd3);
        send_block(1);
        send_block(1);
        send_block(1);
        send_block(2);
        send_block(5);
        send_block(1);
        wait_quiet();
        write_reg(REG_REPORT_THRESHOLD, 24'd0);
        repeat (3) send_block($urandom_range(1, 3));
    endtask

    // With reporting off nothing is flagged, but the count goes on, so the
    // first block after turning it back on is flagged at once. Only the low
    // data bit of the enable register counts.
    task automatic test_report_disabled();
        wait_quiet();
        write_reg(REG_REPORT_THRESHOLD, 24'd2);
        write_reg(REG_REPORT_ENABLE, {23'($urandom()), 1'b0});
        repeat (4) send_block(2);
        wait_quiet();
        write_reg(REG_REPORT_ENABLE, {23'($urandom()), 1'b1});
        send_block(1);
        send_block(1);
    endtask

    // Writes to indexes with no register behind them must change nothing.
    task automatic test_unknown_register();
        wait_quiet();
        write_reg(REG_REPORT_THRESHOLD, THRESHOLD_MAX);
        write_reg(REG_UNUSED_LOW, 24'd1);
        write_reg(REG_UNUSED_TOP, 24'd0);
        write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom()));
        repeat (5) send_block($urandom_range(1, 8));
    endtask

    // Random blocks in several phases, each with fresh register settings.
    // Most blocks are short; a few are long. The first phase runs with no
    // idle cycles on either side.
    task automatic test_random();
        int sent;
        int len;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_quiet();
            case ($urandom_range(4))
                0: write_reg(REG_REPORT_THRESHOLD, 24'd1);
                1: write_reg(REG_REPORT_THRESHOLD, 24'($urandom_range(1, 40)));
                2: write_reg(REG_REPORT_THRESHOLD, 24'($urandom_range(1, 400)));
                3: write_reg(REG_REPORT_THRESHOLD, 24'($urandom_range(1, THRESHOLD_MAX)));
                default: write_reg(REG_REPORT_THRESHOLD, THRESHOLD_MAX);
            endcase
            write_reg(REG_REPORT_ENABLE, 24'($urandom_range(3) != 0));
            no_idle = (phase == 0);
            sent = 0;
            while (sent < RANDOM_FRAMES / RANDOM_PHASES) begin
                if ($urandom_range(19) == 0) len = $urandom_range(13, 200);
                else len = $urandom_range(1, 12);
                send_block(len);
                sent += len;
            end
        end
        no_idle = 1'b0;
    endtask

    // The result side stalls at random, changing at the falling edge.
    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Every result word is checked against the oldest prediction.
    always @(posedge aclk) begin : check_levels
        level_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (levels_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected word: left %0d right %0d report %0b",
                             m_tdata[15:0], m_tdata[31:16], m_tuser);
            end else begin
                want = levels_due.pop_front();
                if (m_tdata[15:0] !== want.left_level || m_tdata[31:16] !== want.right_level ||
                    m_tuser !== want.report) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: left %0d/%0d right %0d/%0d report %0b/%0b",
                                 m_tdata[15:0], want.left_level, m_tdata[31:16],
                                 want.right_level, m_tuser, want.report);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        left_energy         = '0;
        right_energy        = '0;
        block_frames        = '0;
        frames_since_report = '0;
        threshold_now       = THRESHOLD_RESET;
        enable_now          = 1'b1;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_overlong_block();
        test_report_flags();
        test_report_disabled();
        test_unknown_register();
        test_random();
        wait_quiet();
        if (fail_count == 0 && levels_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/srms_pkg.sv
hw/rtl/srms_lane.sv
hw/rtl/srms_merge.sv
hw/rtl/stereo_block_rms_meter.sv
tb/tb.sv
